// ===== rtl/core/dcb_pkg.sv =====
package dcb_pkg;

    localparam int BYTE_COUNT_W = 23;
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 16;
    localparam int COUNT_W      = 11;   // up to 1024 small fragments
    localparam int SMALL_SHIFT  = 13;
    localparam int LARGE_SHIFT  = 16;
    localparam int DESC_BYTES   = 16;

    localparam int IN_TDATA_W   = 88;   // 87 payload bits, padded to bytes
    localparam int OUT_TDATA_W  = 80;
    localparam int OUT_TUSER_W  = 4;

    // input tdata bit positions
    localparam int BYTES_LSB    = 0;
    localparam int BUF_LSB      = BYTE_COUNT_W;
    localparam int TABLE_LSB    = BYTE_COUNT_W + ADDR_W;

    // one emitted descriptor
    typedef struct packed {
        logic              overflow;
        logic              irq_disable;
        logic              last_desc;
        logic              first_desc;
        logic [ADDR_W-1:0] next_addr;
        logic [ADDR_W-1:0] frag_addr;
        logic [SIZE_W-1:0] size_code;
        logic              end_of_run;
    } dcb_desc_t;

    typedef struct packed {
        logic load;     // latch a new request
        logic step;     // emit current descriptor, advance
    } dcb_cmd_t;

    typedef struct packed {
        logic empty;    // request counts zero fragments
        logic closing;  // current descriptor closes the chain
        logic out_free; // output stage can take a descriptor
    } dcb_stat_t;

endpackage

// ===== rtl/core/dcb_ctrl.sv =====
module dcb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dcb_pkg::dcb_stat_t stat,
    output dcb_pkg::dcb_cmd_t  cmd
);
    import dcb_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd.load   = s_tvalid && (state_reg == ST_IDLE);
        cmd.step   = (state_reg == ST_RUN) && stat.out_free;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && !stat.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.step && stat.closing)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/dcb_datapath.sv =====
module dcb_datapath #(
    parameter int MAX_DESC = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             large_fragments,
    input  logic [dcb_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  dcb_pkg::dcb_cmd_t                cmd,
    output logic                             empty,
    output logic                             closing,
    output dcb_pkg::dcb_desc_t               desc
);
    import dcb_pkg::*;

    localparam int EMIT_W = $clog2(MAX_DESC + 1);

    logic [BYTE_COUNT_W-1:0] bytes;
    logic [ADDR_W-1:0]       buf_addr;
    logic [ADDR_W-1:0]       tbl_addr;
    logic [COUNT_W-1:0]      count_whole;
    logic [COUNT_W-1:0]      count;
    logic [SIZE_W-1:0]       remain;
    logic                    ovf;
    logic [EMIT_W-1:0]       emit;
    logic [ADDR_W-1:0]       frag_len;

    logic [ADDR_W-1:0] frag_addr_reg;
    logic [ADDR_W-1:0] next_addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              ovf_reg;
    logic              first_reg;
    logic [EMIT_W-1:0] left_reg;

    assign bytes    = s_tdata[BYTES_LSB +: BYTE_COUNT_W];
    assign buf_addr = s_tdata[BUF_LSB +: ADDR_W];
    assign tbl_addr = s_tdata[TABLE_LSB +: ADDR_W];

    // fragment count by shift and mask
    always_comb
    begin
        if (large_fragments)
        begin
            count_whole = COUNT_W'(bytes >> LARGE_SHIFT);
            remain      = bytes[LARGE_SHIFT-1:0];
            frag_len    = ADDR_W'(1) << LARGE_SHIFT;
        end
        else
        begin
            count_whole = COUNT_W'(bytes >> SMALL_SHIFT);
            remain      = SIZE_W'(bytes[SMALL_SHIFT-1:0]);
            frag_len    = ADDR_W'(1) << SMALL_SHIFT;
        end
        count = count_whole + COUNT_W'(remain != '0);
        ovf   = count > COUNT_W'(MAX_DESC);
        emit  = ovf ? EMIT_W'(MAX_DESC) : count[EMIT_W-1:0];
    end

    assign empty   = (count == '0);
    assign closing = (left_reg == EMIT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            first_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            left_reg  <= emit;
            first_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            left_reg  <= left_reg - EMIT_W'(1);
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frag_addr_reg <= buf_addr;
            next_addr_reg <= tbl_addr + ADDR_W'(DESC_BYTES);
            size_reg      <= remain;
            ovf_reg       <= ovf;
        end
        else if (cmd.step)
        begin
            frag_addr_reg <= frag_addr_reg + frag_len;
            next_addr_reg <= next_addr_reg + ADDR_W'(DESC_BYTES);
        end
    end

    // the partial fragment only shows up on the true last one
    always_comb
    begin
        desc.first_desc  = first_reg;
        desc.last_desc   = closing;
        desc.irq_disable = !closing;
        desc.size_code   = (closing && !ovf_reg) ? size_reg : '0;
        desc.frag_addr   = frag_addr_reg;
        desc.next_addr   = closing ? '0 : next_addr_reg;
        desc.overflow    = ovf_reg;
        desc.end_of_run  = closing;
    end

endmodule

// ===== rtl/core/dcb_out_stage.sv =====
module dcb_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  dcb_pkg::dcb_desc_t                desc,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dcb_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [dcb_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                              m_tlast
);
    import dcb_pkg::*;

    logic      valid_reg;
    dcb_desc_t data_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && out_free)
        begin
            data_reg <= desc;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.next_addr, data_reg.frag_addr, data_reg.size_code};
    assign m_tuser  = {data_reg.overflow, data_reg.irq_disable,
                       data_reg.last_desc, data_reg.first_desc};
    assign m_tlast  = data_reg.end_of_run;

endmodule

// ===== rtl/core/dma_descriptor_chain_builder.sv =====
// Scatter-gather descriptor chain builder. Each request transfer on the s_
// side (byte count, buffer address, descriptor table address) is split into
// 8 KiB or 64 KiB fragments, set by cfg_data bit 0 (reset: 64 KiB), and one
// descriptor per fragment goes out on the m_ side, one per cycle while
// m_tready stays high. A request of N fragments is accepted and then
// yields N descriptors; N is capped at MAX_DESC and overflow then marks
// every descriptor of that request. A zero byte count produces nothing. The
// descriptor generator handles one request at a time; the output register
// lets the next request be accepted while the final descriptor still waits.
// cfg writes are always accepted and must only occur while the block is idle.
module dma_descriptor_chain_builder #(
    parameter int MAX_DESC = 64     // 1 .. 64
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // config: bit 0 = large_fragments
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,

    // request: byte_count[22:0], buffer_addr[54:23], table_addr[86:55]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dcb_pkg::IN_TDATA_W-1:0]  s_tdata,

    // descriptor: size_code[15:0], frag_addr[47:16], next_addr[79:48]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dcb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // first_desc[0], last_desc[1], irq_disable[2], overflow[3]
    output logic [dcb_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                            m_tlast  // end of run
);
    import dcb_pkg::*;

    logic      large_reg;
    dcb_cmd_t  cmd;
    dcb_stat_t stat;
    dcb_desc_t desc;
    logic      empty;
    logic      closing;
    logic      out_free;

    // fragment size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            large_reg <= cfg_data;
        end
    end

    always_comb
    begin
        stat.empty    = empty;
        stat.closing  = closing;
        stat.out_free = out_free;
    end

    dcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dcb_datapath #(
        .MAX_DESC (MAX_DESC)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .large_fragments (large_reg),
        .s_tdata         (s_tdata),
        .cmd             (cmd),
        .empty           (empty),
        .closing         (closing),
        .desc            (desc)
    );

    dcb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.step),
        .desc     (desc),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
